// ----- rtl/core/ptd_pkg.sv -----
// Shared types and constants of the periodic task dispatcher.
// No dependencies; every other file of the block refers to it by scoped name.
package ptd_pkg;

  localparam int TaskSlots = 8;
  localparam int NameLimit = 16;

  localparam int PrioW   = 16;
  localparam int PeriodW = 32;
  localparam int NameW   = 8;
  localparam int SlotW   = 6;
  localparam int WordW   = PrioW + PeriodW + PeriodW;

  localparam logic ActCreate = 1'b0;
  localparam logic ActTick   = 1'b1;

  localparam logic KindCreate   = 1'b0;
  localparam logic KindDispatch = 1'b1;

  typedef enum logic [5:0] {
    StIdle   = 6'b000001,
    StCreate = 6'b000010,
    StCrOut  = 6'b000100,
    StDue    = 6'b001000,
    StMin    = 6'b010000,
    StEmit   = 6'b100000
  } ptd_state_e;

endpackage

// ----- rtl/core/ptd_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Depends on ptd_pkg for default width and depth.
module ptd_ram #(
  parameter int WIDTH = ptd_pkg::WordW,
  parameter int DEPTH = ptd_pkg::TaskSlots,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/ptd_cmp.sv -----
// Shared compare unit: a >= b + c at full width, the sum carried without wrap.
// Depends on ptd_pkg for the operand width.
module ptd_cmp (
  input  logic [ptd_pkg::PeriodW-1:0] a_i,
  input  logic [ptd_pkg::PeriodW-1:0] b_i,
  input  logic [ptd_pkg::PeriodW-1:0] c_i,
  output logic                        ge_o
);

  logic [ptd_pkg::PeriodW:0] sum;

  assign sum  = {1'b0, b_i} + {1'b0, c_i};
  assign ge_o = ({1'b0, a_i} >= sum);

endmodule

// ----- rtl/core/periodic_task_dispatcher_top.sv -----
// Periodic task dispatcher: slot table in RAM, millisecond counter, scan sequencer.
// Depends on ptd_pkg, ptd_ram and ptd_cmp.
//
//   channel | direction | handshake                  | payload
//   in      | input     | in_valid_i / in_stall_o    | action, priority_req, period_ms,
//           |           |                            | name_length
//   out     | output    | out_valid_o / out_stall_i  | kind, ok, due_slot, last
//
// Create: one valid bit tested per cycle.
// Tick: a due scan over the slot table, then a priority scan per dispatch;
// both scans read the slots through the single RAM read port.
// Reset clears the counter, the valid marks and the sequencer; no clearing pass.
// in_stall_o is high whenever an item is in work; a held result stalls the sequencer.
module periodic_task_dispatcher_top #(
  parameter int TASK_SLOTS = ptd_pkg::TaskSlots
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        action_i,
  input  logic [ptd_pkg::PrioW-1:0]   priority_req_i,
  input  logic [ptd_pkg::PeriodW-1:0] period_ms_i,
  input  logic [ptd_pkg::NameW-1:0]   name_length_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        kind_o,
  output logic                        ok_o,
  output logic [ptd_pkg::SlotW-1:0]   due_slot_o,
  output logic                        last_o
);

  localparam int IdxW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TASK_SLOTS - 1);

  ptd_pkg::ptd_state_e state_q, state_d;

  logic [ptd_pkg::PeriodW-1:0] now_q, now_d;
  logic [TASK_SLOTS-1:0]       valid_q, valid_d;
  logic [TASK_SLOTS-1:0]       due_q, due_d, due_clr;
  logic [IdxW-1:0]             scan_idx_q, scan_idx_d;
  logic                        iss_done_q, iss_done_d;
  logic                        dv_q, dv_d;
  logic [IdxW-1:0]             dv_idx_q, dv_idx_d;
  logic                        best_found_q, best_found_d;
  logic [IdxW-1:0]             best_idx_q, best_idx_d;
  logic [ptd_pkg::PrioW-1:0]   best_prio_q, best_prio_d;
  logic [ptd_pkg::PeriodW-1:0] best_period_q, best_period_d;
  logic                        res_ok_q, res_ok_d;
  logic [ptd_pkg::PrioW-1:0]   req_prio_q, req_prio_d;
  logic [ptd_pkg::PeriodW-1:0] req_period_q, req_period_d;

  logic                        out_vld_q, out_vld_d;
  logic                        kind_q, kind_d;
  logic                        ok_q, ok_d;
  logic [ptd_pkg::SlotW-1:0]   slot_q, slot_d;
  logic                        last_q, last_d;
  logic                        out_load, out_free, emit_last;

  logic                        ram_we;
  logic [IdxW-1:0]             ram_waddr;
  logic [ptd_pkg::WordW-1:0]   ram_wdata, ram_rdata;
  logic [ptd_pkg::PrioW-1:0]   rd_prio;
  logic [ptd_pkg::PeriodW-1:0] rd_period, rd_last;

  logic [ptd_pkg::PeriodW-1:0] cmp_a, cmp_b, cmp_c;
  logic                        cmp_ge;

  ptd_ram #(
    .WIDTH(ptd_pkg::WordW),
    .DEPTH(TASK_SLOTS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(scan_idx_q),
    .rdata_o(ram_rdata)
  );

  assign rd_prio   = ram_rdata[ptd_pkg::WordW-1 -: ptd_pkg::PrioW];
  assign rd_period = ram_rdata[2*ptd_pkg::PeriodW-1 -: ptd_pkg::PeriodW];
  assign rd_last   = ram_rdata[ptd_pkg::PeriodW-1:0];

  always_comb begin
    if (state_q == ptd_pkg::StMin) begin
      cmp_a = {{(ptd_pkg::PeriodW-ptd_pkg::PrioW){1'b0}}, rd_prio};
      cmp_b = {{(ptd_pkg::PeriodW-ptd_pkg::PrioW){1'b0}}, best_prio_q};
      cmp_c = '0;
    end else begin
      cmp_a = now_q;
      cmp_b = rd_last;
      cmp_c = rd_period;
    end
  end

  ptd_cmp u_cmp (
    .a_i (cmp_a),
    .b_i (cmp_b),
    .c_i (cmp_c),
    .ge_o(cmp_ge)
  );

  assign out_free = !out_vld_q || !out_stall_i;

  always_comb begin
    due_clr = due_q;
    due_clr[best_idx_q] = 1'b0;
  end
  assign emit_last = (due_clr == '0);

  always_comb begin
    state_d       = state_q;
    now_d         = now_q;
    valid_d       = valid_q;
    due_d         = due_q;
    scan_idx_d    = scan_idx_q;
    iss_done_d    = iss_done_q;
    dv_d          = 1'b0;
    dv_idx_d      = scan_idx_q;
    best_found_d  = best_found_q;
    best_idx_d    = best_idx_q;
    best_prio_d   = best_prio_q;
    best_period_d = best_period_q;
    res_ok_d      = res_ok_q;
    req_prio_d    = req_prio_q;
    req_period_d  = req_period_q;
    ram_we        = 1'b0;
    ram_waddr     = best_idx_q;
    ram_wdata     = {best_prio_q, best_period_q, now_q};
    out_load      = 1'b0;
    kind_d        = kind_q;
    ok_d          = ok_q;
    slot_d        = slot_q;
    last_d        = last_q;

    // advance the read pointer during both RAM scans
    if ((state_q == ptd_pkg::StDue) || (state_q == ptd_pkg::StMin)) begin
      dv_d = !iss_done_q;
      if (!iss_done_q) begin
        if (scan_idx_q == LastIdx) begin
          iss_done_d = 1'b1;
        end else begin
          scan_idx_d = scan_idx_q + 1'b1;
        end
      end
    end

    unique case (state_q)
      ptd_pkg::StIdle: begin
        if (in_valid_i) begin
          scan_idx_d = '0;
          iss_done_d = 1'b0;
          if (action_i == ptd_pkg::ActTick) begin
            now_d   = now_q + 1'b1;
            state_d = ptd_pkg::StDue;
          end else begin
            req_prio_d   = priority_req_i;
            req_period_d = period_ms_i;
            if (name_length_i > ptd_pkg::NameW'(ptd_pkg::NameLimit)) begin
              res_ok_d   = 1'b0;
              best_idx_d = '0;
              state_d    = ptd_pkg::StCrOut;
            end else begin
              state_d = ptd_pkg::StCreate;
            end
          end
        end
      end
      ptd_pkg::StCreate: begin
        if (!valid_q[scan_idx_q]) begin
          ram_we              = 1'b1;
          ram_waddr           = scan_idx_q;
          ram_wdata           = {req_prio_q, req_period_q, now_q};
          valid_d[scan_idx_q] = 1'b1;
          res_ok_d            = 1'b1;
          best_idx_d          = scan_idx_q;
          state_d             = ptd_pkg::StCrOut;
        end else if (scan_idx_q == LastIdx) begin
          res_ok_d   = 1'b0;
          best_idx_d = '0;
          state_d    = ptd_pkg::StCrOut;
        end else begin
          scan_idx_d = scan_idx_q + 1'b1;
        end
      end
      ptd_pkg::StCrOut: begin
        if (out_free) begin
          out_load = 1'b1;
          kind_d   = ptd_pkg::KindCreate;
          ok_d     = res_ok_q;
          slot_d   = ptd_pkg::SlotW'(best_idx_q);
          last_d   = 1'b1;
          state_d  = ptd_pkg::StIdle;
        end
      end
      ptd_pkg::StDue: begin
        if (dv_q) begin
          due_d[dv_idx_q] = valid_q[dv_idx_q] && cmp_ge;
          if (dv_idx_q == LastIdx) begin
            scan_idx_d   = '0;
            iss_done_d   = 1'b0;
            best_found_d = 1'b0;
            state_d      = (due_d == '0) ? ptd_pkg::StIdle : ptd_pkg::StMin;
          end
        end
      end
      ptd_pkg::StMin: begin
        if (dv_q) begin
          if (due_q[dv_idx_q] && (!best_found_q || !cmp_ge)) begin
            best_found_d  = 1'b1;
            best_idx_d    = dv_idx_q;
            best_prio_d   = rd_prio;
            best_period_d = rd_period;
          end
          if (dv_idx_q == LastIdx) begin
            state_d = ptd_pkg::StEmit;
          end
        end
      end
      ptd_pkg::StEmit: begin
        if (out_free) begin
          out_load     = 1'b1;
          kind_d       = ptd_pkg::KindDispatch;
          ok_d         = 1'b1;
          slot_d       = ptd_pkg::SlotW'(best_idx_q);
          last_d       = emit_last;
          ram_we       = 1'b1;
          due_d        = due_clr;
          scan_idx_d   = '0;
          iss_done_d   = 1'b0;
          best_found_d = 1'b0;
          state_d      = emit_last ? ptd_pkg::StIdle : ptd_pkg::StMin;
        end
      end
      default: begin
        state_d = ptd_pkg::StIdle;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ptd_pkg::StIdle;
      now_q        <= '0;
      valid_q      <= '0;
      due_q        <= '0;
      scan_idx_q   <= '0;
      iss_done_q   <= 1'b0;
      dv_q         <= 1'b0;
      best_found_q <= 1'b0;
      out_vld_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      now_q        <= now_d;
      valid_q      <= valid_d;
      due_q        <= due_d;
      scan_idx_q   <= scan_idx_d;
      iss_done_q   <= iss_done_d;
      dv_q         <= dv_d;
      best_found_q <= best_found_d;
      out_vld_q    <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dv_idx_q      <= dv_idx_d;
    best_idx_q    <= best_idx_d;
    best_prio_q   <= best_prio_d;
    best_period_q <= best_period_d;
    res_ok_q      <= res_ok_d;
    req_prio_q    <= req_prio_d;
    req_period_q  <= req_period_d;
    kind_q        <= kind_d;
    ok_q          <= ok_d;
    slot_q        <= slot_d;
    last_q        <= last_d;
  end

  assign in_stall_o  = (state_q != ptd_pkg::StIdle);
  assign out_valid_o = out_vld_q;
  assign kind_o      = kind_q;
  assign ok_o        = ok_q;
  assign due_slot_o  = slot_q;
  assign last_o      = last_q;

endmodule

// ----- tb/periodic_task_dispatcher_top_tb.sv -----
// Self-checking testbench for periodic_task_dispatcher_top: creates and ticks are driven,
// every result is checked against a slot table and millisecond counter kept in the bench.
// Depends on ptd_pkg and the RTL of the block.
`timescale 1ns / 1ps

module periodic_task_dispatcher_top_tb;

  localparam int CycleLimit = 600000;
  localparam int LongHold   = 400;
  localparam int DrainWait  = 8 * (ptd_pkg::TaskSlots + 2) + 40;

  typedef struct packed {
    logic                      kind;
    logic                      ok;
    logic [ptd_pkg::SlotW-1:0] slot;
    logic                      last;
  } sched_res_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  logic action_i;
  logic [ptd_pkg::PrioW-1:0] priority_req_i;
  logic [ptd_pkg::PeriodW-1:0] period_ms_i;
  logic [ptd_pkg::NameW-1:0] name_length_i;
  logic out_valid_o;
  logic out_stall_i;
  logic kind_o;
  logic ok_o;
  logic [ptd_pkg::SlotW-1:0] due_slot_o;
  logic last_o;

  // bench copy of the scheduler state
  logic [ptd_pkg::PeriodW-1:0] clock_ms;
  logic                        slot_live[ptd_pkg::TaskSlots];
  logic [ptd_pkg::PrioW-1:0]   slot_prio[ptd_pkg::TaskSlots];
  logic [ptd_pkg::PeriodW-1:0] slot_period[ptd_pkg::TaskSlots];
  logic [ptd_pkg::PeriodW-1:0] slot_last_run[ptd_pkg::TaskSlots];

  sched_res_t due_q[$];

  bit idle_on;
  bit hold_req;
  int errors;
  int cycles;
  int n_creates;
  int n_refused;
  int n_ticks;
  int n_dispatched;

  periodic_task_dispatcher_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .action_i       (action_i),
    .priority_req_i (priority_req_i),
    .period_ms_i    (period_ms_i),
    .name_length_i  (name_length_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .ok_o           (ok_o),
    .due_slot_o     (due_slot_o),
    .last_o         (last_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic void predict_create(logic [ptd_pkg::PrioW-1:0] prio,
                                         logic [ptd_pkg::PeriodW-1:0] period,
                                         logic [ptd_pkg::NameW-1:0] nlen);
    int free_slot;
    sched_res_t r;
    free_slot = -1;
    if (nlen <= ptd_pkg::NameLimit) begin
      for (int s = ptd_pkg::TaskSlots - 1; s >= 0; s--) begin
        if (!slot_live[s]) free_slot = s;
      end
    end
    r.kind = ptd_pkg::KindCreate;
    r.last = 1'b1;
    if (free_slot >= 0) begin
      slot_live[free_slot]     = 1'b1;
      slot_prio[free_slot]     = prio;
      slot_period[free_slot]   = period;
      slot_last_run[free_slot] = clock_ms;
      r.ok   = 1'b1;
      r.slot = free_slot[ptd_pkg::SlotW-1:0];
    end else begin
      r.ok   = 1'b0;
      r.slot = '0;
      n_refused++;
    end
    due_q.push_back(r);
  endfunction

  function automatic void predict_tick();
    logic       due[ptd_pkg::TaskSlots];
    logic [32:0] deadline;
    sched_res_t batch[$];
    sched_res_t r;
    int best;
    clock_ms = clock_ms + 1;
    for (int s = 0; s < ptd_pkg::TaskSlots; s++) begin
      deadline = {1'b0, slot_last_run[s]} + {1'b0, slot_period[s]};
      due[s] = slot_live[s] && ({1'b0, clock_ms} >= deadline);
    end
    do begin
      best = -1;
      for (int s = 0; s < ptd_pkg::TaskSlots; s++) begin
        if (due[s] && (best < 0 || slot_prio[s] < slot_prio[best])) best = s;
      end
      if (best >= 0) begin
        due[best] = 1'b0;
        slot_last_run[best] = clock_ms;
        r.kind = ptd_pkg::KindDispatch;
        r.ok   = 1'b1;
        r.slot = best[ptd_pkg::SlotW-1:0];
        r.last = 1'b0;
        batch.push_back(r);
      end
    end while (best >= 0);
    if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
    foreach (batch[i]) due_q.push_back(batch[i]);
  endfunction

  task automatic send_item(logic act, logic [ptd_pkg::PrioW-1:0] prio,
                           logic [ptd_pkg::PeriodW-1:0] period,
                           logic [ptd_pkg::NameW-1:0] nlen);
    @(negedge clk_i);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    action_i       <= act;
    priority_req_i <= prio;
    period_ms_i    <= period;
    name_length_i  <= nlen;
    do @(posedge clk_i); while (in_stall_o);
    if (act == ptd_pkg::ActCreate) begin
      n_creates++;
      predict_create(prio, period, nlen);
    end else begin
      n_ticks++;
      predict_tick();
    end
  endtask

  task automatic send_tick();
    send_item(ptd_pkg::ActTick, ptd_pkg::PrioW'($urandom), $urandom,
              ptd_pkg::NameW'($urandom));
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (due_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_empty_ticks();
    send_item(ptd_pkg::ActTick, '0, '0, '0);
    send_item(ptd_pkg::ActTick, '1, '1, '1);
  endtask

  task automatic test_name_limit();
    send_item(ptd_pkg::ActCreate, 16'h0003, 32'd4, ptd_pkg::NameW'(ptd_pkg::NameLimit + 1));
    send_item(ptd_pkg::ActCreate, 16'h0003, 32'd4, 8'hFF);
  endtask

  task automatic test_fill_table();
    send_item(ptd_pkg::ActCreate, 16'hFFFF, 32'd0, ptd_pkg::NameW'(ptd_pkg::NameLimit));
    send_item(ptd_pkg::ActCreate, 16'h0000, 32'hFFFF_FFFF, 8'd0);
    send_item(ptd_pkg::ActCreate, 16'h0005, 32'd1, 8'd1);
    send_item(ptd_pkg::ActCreate, 16'h0005, 32'd3, 8'd7);
    send_item(ptd_pkg::ActCreate, 16'h0000, 32'd2, 8'd16);
    send_item(ptd_pkg::ActCreate, 16'h8000, 32'd7, 8'd9);
    send_item(ptd_pkg::ActCreate, 16'h0005, 32'hFFFF_FFFE, 8'd2);
    send_item(ptd_pkg::ActCreate, 16'h0001, 32'd5, 8'd12);
    repeat (6) send_tick();
  endtask

  task automatic test_table_full();
    send_item(ptd_pkg::ActCreate, 16'h0000, 32'd0, 8'd0);
    send_item(ptd_pkg::ActCreate, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF);
  endtask

  task automatic test_backpressure();
    wait_drained();
    @(negedge clk_i);
    hold_req = 1'b1;
    repeat (12) send_tick();
    wait_drained();
  endtask

  task automatic test_random_traffic(int n_items);
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(0, 99) < 15) begin
        send_item(ptd_pkg::ActCreate, ptd_pkg::PrioW'($urandom), $urandom,
                  ($urandom_range(0, 1) == 0)
                    ? ptd_pkg::NameW'($urandom_range(0, ptd_pkg::NameLimit))
                    : ptd_pkg::NameW'($urandom));
      end else begin
        send_tick();
      end
      if (i == n_items / 2) wait_drained();
    end
  endtask

  // receiver: random stall bursts, plus one long hold on request
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (LongHold - 1) @(negedge clk_i);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 19) - 1) @(negedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    sched_res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (due_q.size() == 0) begin
        $display("%0t: unexpected transfer kind=%0b ok=%0b slot=%0d last=%0b",
                 $time, kind_o, ok_o, due_slot_o, last_o);
        errors++;
      end else begin
        want = due_q.pop_front();
        if (want.kind == ptd_pkg::KindDispatch) n_dispatched++;
        if (kind_o !== want.kind) begin
          $display("%0t: kind expected %0b actual %0b", $time, want.kind, kind_o);
          errors++;
        end
        if (ok_o !== want.ok) begin
          $display("%0t: ok expected %0b actual %0b", $time, want.ok, ok_o);
          errors++;
        end
        if (due_slot_o !== want.slot) begin
          $display("%0t: due_slot expected %0d actual %0d", $time, want.slot, due_slot_o);
          errors++;
        end
        if (last_o !== want.last) begin
          $display("%0t: last expected %0b actual %0b", $time, want.last, last_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("%0t: timeout with %0d results outstanding", $time, due_q.size());
      $display("** periodic_task_dispatcher_top: FAILED **");
      $finish;
    end
  end

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    action_i       = ptd_pkg::ActTick;
    priority_req_i = '0;
    period_ms_i    = '0;
    name_length_i  = '0;
    clock_ms       = '0;
    for (int s = 0; s < ptd_pkg::TaskSlots; s++) begin
      slot_live[s]     = 1'b0;
      slot_prio[s]     = '0;
      slot_period[s]   = '0;
      slot_last_run[s] = '0;
    end
    idle_on = 1'b1;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_ticks();
    test_name_limit();
    test_fill_table();
    test_table_full();
    test_backpressure();
    test_random_traffic(250);
    idle_on = 1'b0;
    test_random_traffic(40);

    wait_drained();
    repeat (DrainWait) @(posedge clk_i);
    $display("Covered %0d creates (%0d refused) and %0d ticks; %0d dispatches checked.",
             n_creates, n_refused, n_ticks, n_dispatched);
    if (errors == 0 && due_q.size() == 0) begin
      $display("** periodic_task_dispatcher_top: PASSED **");
    end else begin
      $display("** periodic_task_dispatcher_top: FAILED **");
    end
    $finish;
  end

endmodule
